// ----- hdl/cec_frame_receiver_defines.svh -----
// assertion macros shared by the cec frame receiver rtl
// no dependencies; modules that use it need clk and rst_n in scope
`ifndef CEC_FRAME_RECEIVER_DEFINES_SVH
`define CEC_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

`define CFR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define CFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFR_ASSERT_ALWAYS(label, cond, msg)

`define CFR_ASSERT_IMP(label, ante, cons, msg)

`define CFR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/cfr_pkg.sv -----
// constants, register map and configuration struct for the cec frame receiver
// no dependencies
package cfr_pkg;

    localparam int MAX_BLOCKS  = 16;
    localparam int MAX_OPCODES = 8;
    localparam int BLK_W       = $clog2(MAX_BLOCKS);

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // register indexes (byte address 8*i)
    localparam logic [2:0] REG_OWN_ADDRESS       = 3'd0;
    localparam logic [2:0] REG_LISTEN_ONLY       = 3'd1;
    localparam logic [2:0] REG_ALLOW_ALL_OPCODES = 3'd2;
    localparam logic [2:0] REG_PROMISCUOUS       = 3'd3;
    localparam logic [2:0] REG_OPCODE_LIST       = 3'd4;
    localparam logic [2:0] REG_OPCODE_COUNT      = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DRIVE = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] BROADCAST_ADDR = 4'hF;

    // pulse timing in 125 kHz ticks
    localparam logic [7:0]  PULSE_ONE      = 8'd75;
    localparam logic [7:0]  PULSE_ZERO     = 8'd187;
    localparam logic [15:0] ONE_ZERO_SPLIT = 16'd131;
    localparam logic [15:0] START_LOW      = 16'd437;
    localparam logic [15:0] START_HIGH     = 16'd487;

    typedef struct packed {
        logic [3:0]  own_address;
        logic        listen_only;
        logic        allow_all_opcodes;
        logic        promiscuous;
        logic [63:0] opcode_list;
        logic [3:0]  opcode_count;
    } cfg_t;

endpackage

// ----- hdl/cfr_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/cfr_regs.sv -----
// apb configuration registers of the cec frame receiver
// depends on cfr_pkg
module cfr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfr_pkg::PADDR_W-1:0] paddr,
    input  logic [cfr_pkg::PDATA_W-1:0] pwdata,
    output logic [cfr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output cfr_pkg::cfg_t               cfg
);

    cfr_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[cfr_pkg::PADDR_W-1:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address       <= cfr_pkg::BROADCAST_ADDR;
            cfg_reg.listen_only       <= 1'b0;
            cfg_reg.allow_all_opcodes <= 1'b0;
            cfg_reg.promiscuous       <= 1'b0;
            cfg_reg.opcode_list       <= '0;
            cfg_reg.opcode_count      <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                cfr_pkg::REG_OWN_ADDRESS:       cfg_reg.own_address       <= pwdata[3:0];
                cfr_pkg::REG_LISTEN_ONLY:       cfg_reg.listen_only       <= pwdata[0];
                cfr_pkg::REG_ALLOW_ALL_OPCODES: cfg_reg.allow_all_opcodes <= pwdata[0];
                cfr_pkg::REG_PROMISCUOUS:       cfg_reg.promiscuous       <= pwdata[0];
                cfr_pkg::REG_OPCODE_LIST:       cfg_reg.opcode_list       <= pwdata;
                cfr_pkg::REG_OPCODE_COUNT:      cfg_reg.opcode_count      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            cfr_pkg::REG_OWN_ADDRESS:       prdata[3:0] = cfg_reg.own_address;
            cfr_pkg::REG_LISTEN_ONLY:       prdata[0]   = cfg_reg.listen_only;
            cfr_pkg::REG_ALLOW_ALL_OPCODES: prdata[0]   = cfg_reg.allow_all_opcodes;
            cfr_pkg::REG_PROMISCUOUS:       prdata[0]   = cfg_reg.promiscuous;
            cfr_pkg::REG_OPCODE_LIST:       prdata      = cfg_reg.opcode_list;
            cfr_pkg::REG_OPCODE_COUNT:      prdata[3:0] = cfg_reg.opcode_count;
            default: ;
        endcase
    end

endmodule

// ----- hdl/cfr_opmatch.sv -----
// opcode list lookup: compares one opcode against the valid list entries
// depends on cfr_pkg
module cfr_opmatch (
    input  logic [63:0] opcode_list,
    input  logic [3:0]  opcode_count,
    input  logic [7:0]  opcode,
    output logic        hit
);

    logic [3:0] count_eff;

    // counts above the list length act as a full list
    assign count_eff = (opcode_count > 4'(cfr_pkg::MAX_OPCODES)) ?
                       4'(cfr_pkg::MAX_OPCODES) : opcode_count;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < cfr_pkg::MAX_OPCODES; i++)
        begin
            if ((4'(i) < count_eff) && (opcode_list[8*i +: 8] == opcode))
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/cec_frame_receiver.sv -----
// cec frame receiver top level: edge sequencer, frame byte store, result register
// depends on cfr_pkg, cfr_ram, cfr_regs, cfr_opmatch and cec_frame_receiver_defines.svh
//
//   port group   direction  handshake                 beat contents
//   edge         in         edge_valid / edge_stall   edge_rising, low_ticks
//   result       out        result_valid / result_stall  kind, drive_low_ticks,
//                                                        byte_value, byte_acked,
//                                                        byte_index, last
//   apb          in         psel / penable / pready   register write and read
//
// an edge beat is taken in ST_WAIT; a data bit then passes through ST_RMW (read,
// modify and write back of its frame byte), the opcode check after the eom bit
// of block one through ST_OPC; frame delivery alternates ST_DRD (one byte store read)
// and ST_DOUT and holds the edge port to its end; single results pass through ST_EMIT
// reset is asynchronous and clears control state only; the byte store is cleared
// by valid bits at each start bit taken while idle, no clearing pass
// result_stall holds the result register and the sequencer waits on it
`include "cec_frame_receiver_defines.svh"

module cec_frame_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        edge_valid,
    output logic                        edge_stall,
    input  logic                        edge_rising,
    input  logic [15:0]                 low_ticks,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  kind,
    output logic [7:0]                  drive_low_ticks,
    output logic [7:0]                  byte_value,
    output logic                        byte_acked,
    output logic [3:0]                  byte_index,
    output logic                        last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfr_pkg::PADDR_W-1:0] paddr,
    input  logic [cfr_pkg::PDATA_W-1:0] pwdata,
    output logic [cfr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int BW = cfr_pkg::BLK_W;
    localparam int NB = cfr_pkg::MAX_BLOCKS;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_START,
        LS_RX,
        LS_ACK,
        LS_NACK
    } line_t;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_RMW,
        ST_OPC,
        ST_EMIT,
        ST_DRD,
        ST_DOUT
    } step_t;

    cfr_pkg::cfg_t cfg;

    step_t          step_reg, step_next;
    line_t          ls_reg, ls_next;
    logic [3:0]     bitpos_reg, bitpos_next;
    logic [BW-1:0]  blkpos_reg, blkpos_next;
    logic [NB-1:0]  valid_reg, valid_next;
    logic [NB-1:0]  eom_reg, eom_next;
    logic [NB-1:0]  ackm_reg, ackm_next;
    logic [3:0]     dest_reg, dest_next;
    logic           bit_reg, bit_next;
    logic [BW-1:0]  idx_reg, idx_next;
    logic [BW-1:0]  last_idx_reg, last_idx_next;
    logic [1:0]     pend_kind_reg, pend_kind_next;
    logic [7:0]     pend_drive_reg, pend_drive_next;

    logic           rvalid_reg, rvalid_next;
    logic [1:0]     kind_reg, kind_next;
    logic [7:0]     drive_reg, drive_next;
    logic [7:0]     bval_reg, bval_next;
    logic           backed_reg, backed_next;
    logic [3:0]     bidx_reg, bidx_next;
    logic           last_reg, last_next;

    logic           ram_we;
    logic [BW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [BW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    logic           take;
    logic           slot_free;
    logic           is_over;
    logic           is_start;
    logic           data_bit;
    logic           good;
    logic           is_final;
    logic [7:0]     cur_byte;
    logic [7:0]     new_byte;
    logic [7:0]     op_byte;
    logic           op_hit;

    cfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (NB)
    ) u_bytes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfr_opmatch u_opmatch (
        .opcode_list  (cfg.opcode_list),
        .opcode_count (cfg.opcode_count),
        .opcode       (op_byte),
        .hit          (op_hit)
    );

    assign edge_stall = (step_reg != ST_WAIT);
    assign take       = edge_valid && (step_reg == ST_WAIT);
    assign slot_free  = !rvalid_reg || !result_stall;

    assign is_over  = (low_ticks > cfr_pkg::START_HIGH);
    assign is_start = !is_over && (low_ticks >= cfr_pkg::START_LOW);
    assign data_bit = (low_ticks < cfr_pkg::ONE_ZERO_SPLIT);

    assign good     = (dest_reg != cfr_pkg::BROADCAST_ADDR) ? !data_bit : data_bit;
    assign is_final = eom_reg[blkpos_reg] || !good || (blkpos_reg == BW'(NB - 1));

    // entries not written since the last start read as zero
    assign cur_byte = valid_reg[blkpos_reg] ? ram_rdata : 8'h00;
    assign new_byte = cur_byte | (bit_reg ? (8'h80 >> bitpos_reg[2:0]) : 8'h00);
    assign op_byte  = valid_reg[1] ? ram_rdata : 8'h00;

    assign result_valid    = rvalid_reg;
    assign kind            = kind_reg;
    assign drive_low_ticks = drive_reg;
    assign byte_value      = bval_reg;
    assign byte_acked      = backed_reg;
    assign byte_index      = bidx_reg;
    assign last            = last_reg;

    always_comb
    begin
        step_next       = step_reg;
        ls_next         = ls_reg;
        bitpos_next     = bitpos_reg;
        blkpos_next     = blkpos_reg;
        valid_next      = valid_reg;
        eom_next        = eom_reg;
        ackm_next       = ackm_reg;
        dest_next       = dest_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        pend_kind_next  = pend_kind_reg;
        pend_drive_next = pend_drive_reg;

        rvalid_next = rvalid_reg && result_stall;
        kind_next   = kind_reg;
        drive_next  = drive_reg;
        bval_next   = bval_reg;
        backed_next = backed_reg;
        bidx_next   = bidx_reg;
        last_next   = last_reg;

        ram_we    = 1'b0;
        ram_waddr = blkpos_reg;
        ram_wdata = new_byte;
        ram_re    = 1'b0;
        ram_raddr = blkpos_reg;

        unique case (step_reg)
            ST_WAIT:
            begin
                if (take)
                begin
                    if (!edge_rising)
                    begin
                        if (ls_reg == LS_ACK || ls_reg == LS_NACK)
                        begin
                            pend_kind_next  = cfr_pkg::KIND_DRIVE;
                            pend_drive_next = (ls_reg == LS_ACK) ?
                                              cfr_pkg::PULSE_ZERO : cfr_pkg::PULSE_ONE;
                            ls_next         = LS_RX;
                            step_next       = ST_EMIT;
                        end
                    end
                    else if (is_over)
                    begin
                        // out-of-range pulse leaves everything as it is
                    end
                    else if (is_start)
                    begin
                        if (ls_reg != LS_IDLE)
                        begin
                            ls_next         = LS_IDLE;
                            pend_kind_next  = cfr_pkg::KIND_ERROR;
                            pend_drive_next = 8'd0;
                            step_next       = ST_EMIT;
                        end
                        else
                        begin
                            valid_next  = '0;
                            eom_next    = '0;
                            ackm_next   = '0;
                            bitpos_next = 4'd0;
                            blkpos_next = '0;
                            dest_next   = 4'd0;
                            ls_next     = LS_START;
                        end
                    end
                    else if (ls_reg == LS_START || ls_reg == LS_RX)
                    begin
                        ls_next = LS_RX;
                        if (bitpos_reg < 4'd8)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = blkpos_reg;
                            bit_next  = data_bit;
                            step_next = ST_RMW;
                        end
                        else if (bitpos_reg == 4'd8)
                        begin
                            // eom bit: decide the acknowledge pulse
                            eom_next[blkpos_reg] = eom_reg[blkpos_reg] | data_bit;
                            bitpos_next          = 4'd9;
                            if (!cfg.listen_only)
                            begin
                                ls_next = LS_NACK;
                                if (dest_reg != cfr_pkg::BROADCAST_ADDR &&
                                    dest_reg == cfg.own_address)
                                begin
                                    if (blkpos_reg != BW'(1) || cfg.allow_all_opcodes)
                                    begin
                                        ls_next = LS_ACK;
                                    end
                                    else
                                    begin
                                        ram_re    = 1'b1;
                                        ram_raddr = BW'(1);
                                        step_next = ST_OPC;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            // acknowledge bit closes the block
                            if (good)
                            begin
                                ackm_next[blkpos_reg] = 1'b1;
                            end
                            bitpos_next = 4'd0;
                            blkpos_next = blkpos_reg + BW'(1);
                            if (is_final)
                            begin
                                ls_next = LS_IDLE;
                                if (dest_reg == cfg.own_address ||
                                    dest_reg == cfr_pkg::BROADCAST_ADDR ||
                                    cfg.promiscuous)
                                begin
                                    idx_next      = '0;
                                    last_idx_next = blkpos_reg;
                                    step_next     = ST_DRD;
                                end
                            end
                        end
                    end
                end
            end

            ST_RMW:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = blkpos_reg;
                ram_wdata              = new_byte;
                valid_next[blkpos_reg] = 1'b1;
                if (blkpos_reg == '0)
                begin
                    dest_next = new_byte[3:0];
                end
                bitpos_next = bitpos_reg + 4'd1;
                step_next   = ST_WAIT;
            end

            ST_OPC:
            begin
                if (op_hit)
                begin
                    ls_next = LS_ACK;
                end
                step_next = ST_WAIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rvalid_next = 1'b1;
                    kind_next   = pend_kind_reg;
                    drive_next  = pend_drive_reg;
                    bval_next   = 8'd0;
                    backed_next = 1'b0;
                    bidx_next   = 4'd0;
                    last_next   = 1'b1;
                    step_next   = ST_WAIT;
                end
            end

            ST_DRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg;
                step_next = ST_DOUT;
            end

            ST_DOUT:
            begin
                if (slot_free)
                begin
                    rvalid_next = 1'b1;
                    kind_next   = cfr_pkg::KIND_BYTE;
                    drive_next  = 8'd0;
                    bval_next   = valid_reg[idx_reg] ? ram_rdata : 8'h00;
                    backed_next = ackm_reg[idx_reg];
                    bidx_next   = 4'(idx_reg);
                    last_next   = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        step_next = ST_WAIT;
                    end
                    else
                    begin
                        idx_next  = idx_reg + BW'(1);
                        step_next = ST_DRD;
                    end
                end
            end

            default:
            begin
                step_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_WAIT;
            ls_reg      <= LS_IDLE;
            bitpos_reg  <= 4'd0;
            blkpos_reg  <= '0;
            valid_reg   <= '0;
            eom_reg     <= '0;
            ackm_reg    <= '0;
            dest_reg    <= 4'd0;
            idx_reg     <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            ls_reg      <= ls_next;
            bitpos_reg  <= bitpos_next;
            blkpos_reg  <= blkpos_next;
            valid_reg   <= valid_next;
            eom_reg     <= eom_next;
            ackm_reg    <= ackm_next;
            dest_reg    <= dest_next;
            idx_reg     <= idx_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        bit_reg        <= bit_next;
        last_idx_reg   <= last_idx_next;
        pend_kind_reg  <= pend_kind_next;
        pend_drive_reg <= pend_drive_next;
        kind_reg       <= kind_next;
        drive_reg      <= drive_next;
        bval_reg       <= bval_next;
        backed_reg     <= backed_next;
        bidx_reg       <= bidx_next;
        last_reg       <= last_next;
    end

    `CFR_ASSERT_ALWAYS(a_bitpos_range, bitpos_reg <= 4'd9, "bit position beyond ack bit")
    `CFR_ASSERT_IMP(a_pending_after_eom, ls_reg == LS_ACK || ls_reg == LS_NACK, bitpos_reg == 4'd9, "ack pulse pending outside ack bit slot")
    `CFR_ASSERT_NEXT(a_read_then_out, step_reg == ST_DRD, step_reg == ST_DOUT, "frame read not followed by delivery")
    `CFR_ASSERT_IMP(a_dump_bound, step_reg == ST_DOUT, idx_reg <= last_idx_reg, "delivery index past final block")
    `CFR_ASSERT_IMP(a_ram_one_access, ram_we, !ram_re, "byte store read and written in one cycle")

endmodule
